// ===== design/stp_pkg.sv =====
// package for the spanning tree bpdu engine: sizes, vector type, codes
`default_nettype none
package stp_pkg;
   localparam int NPORTS = 8;
   localparam int PW = (NPORTS > 1) ? $clog2(NPORTS) : 1;
   localparam int PC = $clog2(NPORTS + 1);

   typedef struct packed {
      logic [63:0] root;
      logic [31:0] cost;
      logic [63:0] bridge;
      logic [15:0] ident;
   } vec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_ELECT,
      ST_SETROOT,
      ST_UPDATE,
      ST_SEND,
      ST_INIT
   } state_type;

   localparam logic [2:0] REG_BRIDGE_ID = 3'd0;
   localparam logic [2:0] REG_PORT_PRIO = 3'd1;
   localparam logic [2:0] REG_PORTS     = 3'd2;
   localparam logic [2:0] REG_HELLO     = 3'd3;
   localparam logic [2:0] REG_COST      = 3'd4;

   // true when a is strictly better (smaller) than b
   function automatic logic vec_better(vec_type a, vec_type b);
      return {a.root, a.cost, a.bridge, a.ident} < {b.root, b.cost, b.bridge, b.ident};
   endfunction
endpackage
`default_nettype wire

// ===== design/stp_vec_ram.sv =====
// port vector store: one vector register per port, one write and one read port
`default_nettype none
module stp_vec_ram
   import stp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [PW-1:0] wr_addr,
   input  vec_type            wr_data,
   input  wire logic [PW-1:0] rd_addr,
   output vec_type            rd_data
);
   vec_type mem_ff [NPORTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_addr];
endmodule
`default_nettype wire

// ===== design/spanning_tree_bpdu_engine_core.sv =====
// top level of the spanning tree bpdu engine: sequencer, compare unit, vector store
// usage:
//  req_ channel carries one word: a received config bpdu (req_func 0) or a
//  hello tick (req_func 1). rsp_ channel carries the bpdus sent, in ascending
//  port order, rsp_last marking the final word of the item.
//  csr_ port writes a register at any edge with csr_we high; the user must write only while idle,
//  as the block itself does not enforce it. a write of bridge id, port priority or port
//  count rebuilds every port vector, one port a cycle (req_ready low meanwhile).
//  timing: an item walks the ports one vector per cycle through one shared
//  vector comparator while the receiver keeps up; req_ready stays low until
//  the item is done, so the next word is taken only back in idle. words
//  leave as the walk finds them, but one is held back to mark the last.
//  at reset the block runs the same rebuild pass before taking words.
//  a stalled receiver holds the output register; the sequencer waits on it.
`default_nettype none
module spanning_tree_bpdu_engine_core
   import stp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [2:0]  req_rx_port,
   input  wire logic [63:0] req_rx_root_id,
   input  wire logic [31:0] req_rx_root_cost,
   input  wire logic [63:0] req_rx_bridge_id,
   input  wire logic [15:0] req_rx_port_id,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_tx_port,
   output logic [63:0]      rsp_tx_root_id,
   output logic [31:0]      rsp_tx_root_cost,
   output logic [63:0]      rsp_tx_bridge_id,
   output logic [15:0]      rsp_tx_port_id,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   // config registers
   logic [63:0] bridge_id_ff;
   logic [7:0]  prio_ff;
   logic [3:0]  ports_ff;
   logic [15:0] hello_ff;
   logic [15:0] cost_ff;
   logic        restart;

   always_ff @(posedge clock) begin
      if (reset) begin
         bridge_id_ff <= '0;
         prio_ff      <= 8'd128;
         ports_ff     <= 4'd8;
         hello_ff     <= 16'd2;
         cost_ff      <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_BRIDGE_ID: bridge_id_ff <= csr_wdata;
            REG_PORT_PRIO: prio_ff <= csr_wdata[7:0];
            REG_PORTS:     ports_ff <= csr_wdata[3:0];
            REG_HELLO:     hello_ff <= csr_wdata[15:0];
            REG_COST:      cost_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_we && (csr_index == REG_BRIDGE_ID || csr_index == REG_PORT_PRIO ||
                               csr_index == REG_PORTS);

   // active port count, clamped to 1..NPORTS
   logic [PC-1:0] nact;
   always_comb begin
      if (ports_ff == 4'd0) nact = PC'(1);
      else if (32'(ports_ff) > NPORTS) nact = PC'(NPORTS);
      else nact = PC'(ports_ff);
   end

   // state
   state_type   state_ff, state_in;
   logic [PC-1:0] idx_ff, idx_in;
   logic [PC-1:0] best_ff, best_in;     // NPORTS means none
   logic [PC-1:0] rootp_ff, rootp_in;
   logic [63:0] broot_ff, broot_in;
   logic [31:0] bcost_ff, bcost_in;
   logic        hen_ff, hen_in;
   logic [15:0] hcnt_ff, hcnt_in;
   vec_type     rx_ff;
   vec_type     bestv_ff, bestv_in;
   logic        upd_ff, upd_in;         // send pass done, held word still to flush
   // pending output word waiting for a later designated port to mark last
   logic        pend_ff, pend_in;
   vec_type     pendv_ff, pendv_in;
   logic [PW-1:0] pendp_ff, pendp_in;
   logic        ov_ff, ov_in;
   logic        ol_ff, ol_in;
   vec_type     ovec_ff, ovec_in;
   logic [PW-1:0] oport_ff, oport_in;

   // vector store
   logic        wr_en;
   logic [PW-1:0] wr_addr, rd_addr;
   vec_type     wr_data, rd_data;

   stp_vec_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [PW-1:0] idx_p;
   logic [15:0]   own_id;
   logic          desig;
   logic          at_end;
   vec_type       cmp_a, cmp_b;
   logic          better;
   vec_type       mine;
   logic [32:0]   csum;

   assign idx_p  = idx_ff[PW-1:0];
   assign own_id = {prio_ff, 8'(32'(idx_ff) + 1)};
   assign desig  = (rd_data.bridge == bridge_id_ff) && (rd_data.ident == own_id);
   assign at_end = (idx_ff == nact - PC'(1));
   assign better = vec_better(cmp_a, cmp_b);
   assign mine   = '{root: broot_ff, cost: bcost_ff, bridge: bridge_id_ff, ident: own_id};
   assign csum   = {1'b0, bestv_ff.cost} + {17'd0, cost_ff};

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= ST_INIT;
         idx_ff   <= '0;
         broot_ff <= csr_we && csr_index == REG_BRIDGE_ID ? csr_wdata
                     : (reset ? 64'd0 : bridge_id_ff);
         bcost_ff <= '0;
         rootp_ff <= PC'(NPORTS);
         hen_ff   <= 1'b1;
         hcnt_ff  <= '0;
         ov_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         upd_ff   <= 1'b0;
         best_ff  <= PC'(NPORTS);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         broot_ff <= broot_in;
         bcost_ff <= bcost_in;
         rootp_ff <= rootp_in;
         hen_ff   <= hen_in;
         hcnt_ff  <= hcnt_in;
         ov_ff    <= ov_in;
         pend_ff  <= pend_in;
         upd_ff   <= upd_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      bestv_ff <= bestv_in;
      pendv_ff <= pendv_in;
      pendp_ff <= pendp_in;
      ol_ff    <= ol_in;
      ovec_ff  <= ovec_in;
      oport_ff <= oport_in;
      if (req_valid && req_ready) begin
         rx_ff   <= '{root: req_rx_root_id, cost: req_rx_root_cost,
                      bridge: req_rx_bridge_id, ident: req_rx_port_id};
      end
   end

   // next state
   logic out_free;
   assign out_free = !ov_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      broot_in = broot_ff;
      bcost_in = bcost_ff;
      rootp_in = rootp_ff;
      hen_in   = hen_ff;
      hcnt_in  = hcnt_ff;
      best_in  = best_ff;
      bestv_in = bestv_ff;
      upd_in   = upd_ff;
      pend_in  = pend_ff;
      pendv_in = pendv_ff;
      pendp_in = pendp_ff;
      ov_in    = ov_ff && !rsp_ready;
      ol_in    = ol_ff;
      ovec_in  = ovec_ff;
      oport_in = oport_ff;
      rd_addr  = idx_p;
      wr_en    = 1'b0;
      wr_addr  = idx_p;
      wr_data  = rd_data;
      cmp_a    = rx_ff;
      cmp_b    = rd_data;
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '{root: bridge_id_ff, cost: 32'd0, bridge: bridge_id_ff, ident: own_id};
            broot_in = bridge_id_ff;
            if (idx_ff == PC'(NPORTS - 1)) begin
               idx_in = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + PC'(1);
            end
         end
         ST_IDLE: begin
            idx_in  = '0;
            pend_in = 1'b0;
            best_in = PC'(NPORTS);
            upd_in  = 1'b0;
            if (req_valid) begin
               if (req_func) begin
                  if (hen_ff) begin
                     if (hcnt_ff + 16'd1 >= ((hello_ff == 16'd0) ? 16'd1 : hello_ff)
                         && hcnt_ff != 16'hFFFF) begin
                        hcnt_in  = '0;
                        state_in = ST_SEND;
                     end else begin
                        hcnt_in = hcnt_ff + 16'd1;
                     end
                  end
               end else if (PC'(req_rx_port) < nact) begin
                  idx_in   = PC'(req_rx_port);
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            // shared comparator: received vector against stored one
            if (better) begin
               wr_en   = 1'b1;
               wr_data = rx_ff;
               idx_in  = '0;
               state_in = ST_ELECT;
            end else if (desig) begin
               if (out_free) begin
                  ov_in = 1'b1; ol_in = 1'b1; ovec_in = rd_data; oport_in = idx_p;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ELECT: begin
            cmp_a = rd_data;
            cmp_b = bestv_ff;
            if (!desig && (best_ff == PC'(NPORTS) || better)) begin
               best_in  = idx_ff;
               bestv_in = rd_data;
            end
            if (at_end) state_in = ST_SETROOT;
            else idx_in = idx_ff + PC'(1);
         end
         ST_SETROOT: begin
            rootp_in = best_ff;
            idx_in   = '0;
            if (best_ff == PC'(NPORTS)) begin
               broot_in = bridge_id_ff;
               bcost_in = '0;
            end else begin
               broot_in = bestv_ff.root;
               bcost_in = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // one pass: each port that is designated or, the root port apart, beaten takes our root and cost
            cmp_a = mine;
            cmp_b = rd_data;
            if (desig || (idx_ff != rootp_ff && better)) begin
               wr_en   = 1'b1;
               wr_data = '{root: broot_ff, cost: bcost_ff, bridge: bridge_id_ff, ident: own_id};
            end
            if (at_end) begin
               idx_in = '0;
               if (broot_ff != bridge_id_ff) hen_in = 1'b0;
               state_in = ST_SEND;
            end else begin
               idx_in = idx_ff + PC'(1);
            end
         end
         ST_SEND: begin
            // walk designated ports; hold one word back to find the last one
            if (out_free || !(pend_ff && (desig || at_end))) begin
               if (desig) begin
                  if (pend_ff) begin
                     ov_in = 1'b1; ol_in = 1'b0; ovec_in = pendv_ff; oport_in = pendp_ff;
                  end
                  pend_in = 1'b1; pendv_in = rd_data; pendp_in = idx_p;
               end
               if (at_end) begin
                  if (desig || pend_ff) begin
                     // held word goes out as the last one in the flush that follows
                     pend_in = 1'b1;
                     state_in = ST_SEND;
                     idx_in = idx_ff;
                     upd_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + PC'(1);
               end
               if (upd_ff) begin
                  // flush: the held word is the last one
                  wr_en = 1'b0;
                  if (out_free) begin
                     ov_in = 1'b1; ol_in = 1'b1; ovec_in = pendv_ff; oport_in = pendp_ff;
                     pend_in = 1'b0; upd_in = 1'b0;
                     state_in = ST_IDLE;
                  end else begin
                     ov_in = ov_ff; pend_in = pend_ff; pendv_in = pendv_ff;
                     pendp_in = pendp_ff; state_in = ST_SEND; upd_in = 1'b1;
                  end
               end
            end else if (upd_ff) begin
               state_in = ST_SEND;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
   end

   assign rsp_valid        = ov_ff;
   assign rsp_last         = ol_ff;
   assign rsp_tx_port      = 3'(oport_ff);
   assign rsp_tx_root_id   = ovec_ff.root;
   assign rsp_tx_root_cost = ovec_ff.cost;
   assign rsp_tx_bridge_id = ovec_ff.bridge;
   assign rsp_tx_port_id   = ovec_ff.ident;
endmodule
`default_nettype wire
